// ===== rtl/wrr_pkg.sv =====
package wrr_pkg;

   typedef enum logic [1:0] {
      REQ_LOAD   = 2'd0,
      REQ_DISC   = 2'd1,
      REQ_SQUARE = 2'd2,
      REQ_RENDER = 2'd3
   } req_code_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_CLEAR,
      OP_ACCEPT,
      OP_DCHK,
      OP_DBASE,
      OP_DROW,
      OP_DCOL,
      OP_RSET,
      OP_RIDX,
      OP_RRD,
      OP_RSUM,
      OP_RWR,
      OP_RMUL,
      OP_ROFF,
      OP_RSRC,
      OP_RSWT,
      OP_ROUT
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic drop_ok;
      logic row_end;
      logic col_last;
      logic rd_last;
   } dp_status_type;

   localparam int CSR_DW = 9;
   localparam int CSR_IW = 2;
   localparam logic [CSR_IW-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_IW-1:0] CSR_FRAME_HEIGHT = 2'd1;
   localparam logic [CSR_DW-1:0] DIM_RESET        = 9'd256;

   localparam int MIN_DIM      = 3;
   localparam int DAMP_SHIFT   = 5;
   localparam int SPREAD_SHIFT = 1;

   localparam int TAP_W = 3;
   localparam int NUM_TAPS = 5;
   localparam logic [TAP_W-1:0] TAP_WEST   = 3'd0;
   localparam logic [TAP_W-1:0] TAP_EAST   = 3'd1;
   localparam logic [TAP_W-1:0] TAP_NORTH  = 3'd2;
   localparam logic [TAP_W-1:0] TAP_SOUTH  = 3'd3;
   localparam logic [TAP_W-1:0] TAP_CENTRE = 3'd4;

endpackage

// ===== rtl/wrr_channels.sv =====
interface wrr_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         req_type;
   logic [15:0]        load_index;
   logic [31:0]        pixel_data;
   logic [7:0]         center_x;
   logic [7:0]         center_y;
   logic [7:0]         radius;
   logic signed [15:0] depth;

   modport source (output valid, req_type, load_index, pixel_data, center_x, center_y,
                   radius, depth, input ready);
   modport sink (input valid, req_type, load_index, pixel_data, center_x, center_y,
                 radius, depth, output ready);
endinterface

interface wrr_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] out_index;
   logic [31:0] out_pixel;
   logic        frame_done;

   modport source (output valid, out_index, out_pixel, frame_done, input ready);
   modport sink (input valid, out_index, out_pixel, frame_done, output ready);
endinterface

// ===== rtl/wrr_ram.sv =====
module wrr_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/wrr_ctrl.sv =====
module wrr_ctrl
   import wrr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic [1:0]    req_type,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   typedef enum logic [16:0] {
      ST_CLEAR = 17'd1 << 0,
      ST_IDLE  = 17'd1 << 1,
      ST_DCHK  = 17'd1 << 2,
      ST_DBASE = 17'd1 << 3,
      ST_DROW  = 17'd1 << 4,
      ST_DCOL  = 17'd1 << 5,
      ST_RSET  = 17'd1 << 6,
      ST_RIDX  = 17'd1 << 7,
      ST_RRD   = 17'd1 << 8,
      ST_RDRN  = 17'd1 << 9,
      ST_RSUM  = 17'd1 << 10,
      ST_RWR   = 17'd1 << 11,
      ST_RMUL  = 17'd1 << 12,
      ST_ROFF  = 17'd1 << 13,
      ST_RSRC  = 17'd1 << 14,
      ST_RSWT  = 17'd1 << 15,
      ST_ROUT  = 17'd1 << 16
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd.op       = OP_NONE;
      req_ready    = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.op = OP_CLEAR;
            if (status.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op = OP_ACCEPT;
               case (req_type)
                  REQ_DISC, REQ_SQUARE: state_in = ST_DCHK;
                  REQ_RENDER:           state_in = ST_RSET;
                  default:              state_in = ST_IDLE;
               endcase
            end
         end
         ST_DCHK: begin
            cmd.op   = OP_DCHK;
            state_in = status.drop_ok ? ST_DBASE : ST_IDLE;
         end
         ST_DBASE: begin
            cmd.op   = OP_DBASE;
            state_in = ST_DROW;
         end
         ST_DROW: begin
            cmd.op   = OP_DROW;
            state_in = status.row_end ? ST_IDLE : ST_DCOL;
         end
         ST_DCOL: begin
            cmd.op = OP_DCOL;
            if (status.col_last) state_in = ST_DROW;
         end
         ST_RSET: begin
            cmd.op   = OP_RSET;
            state_in = ST_RIDX;
         end
         ST_RIDX: begin
            cmd.op   = OP_RIDX;
            state_in = ST_RRD;
         end
         ST_RRD: begin
            cmd.op = OP_RRD;
            if (status.rd_last) state_in = ST_RDRN;
         end
         ST_RDRN: state_in = ST_RSUM;
         ST_RSUM: begin
            cmd.op   = OP_RSUM;
            state_in = ST_RWR;
         end
         ST_RWR: begin
            cmd.op   = OP_RWR;
            state_in = ST_RMUL;
         end
         ST_RMUL: begin
            cmd.op   = OP_RMUL;
            state_in = ST_ROFF;
         end
         ST_ROFF: begin
            cmd.op   = OP_ROFF;
            state_in = ST_RSRC;
         end
         ST_RSRC: begin
            cmd.op   = OP_RSRC;
            state_in = ST_RSWT;
         end
         ST_RSWT: begin
            cmd.op   = OP_RSWT;
            state_in = ST_ROUT;
         end
         ST_ROUT: begin
            // The result register must be empty, or emptied this cycle.
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op       = OP_ROUT;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/wrr_dp.sv =====
module wrr_dp
   import wrr_pkg::*;
#(
   parameter int MAX_DIM    = 256,
   parameter int MAX_PIXELS = 65536
) (
   input  logic               clock,
   input  logic               reset,
   input  dp_cmd_type         cmd,
   output dp_status_type      status,
   input  logic               csr_we,
   input  logic [CSR_IW-1:0]  csr_index,
   input  logic [CSR_DW-1:0]  csr_wdata,
   input  logic [1:0]         req_type,
   input  logic [15:0]        load_index,
   input  logic [31:0]        pixel_data,
   input  logic [7:0]         center_x,
   input  logic [7:0]         center_y,
   input  logic [7:0]         radius,
   input  logic signed [15:0] depth,
   output logic [15:0]        out_index,
   output logic [31:0]        out_pixel,
   output logic               frame_done
);

   localparam int DIMW = $clog2(MAX_DIM + 1);
   localparam int PIXW = $clog2(MAX_DIM * MAX_DIM + 1);
   localparam int AW   = $clog2(MAX_PIXELS);
   localparam int CW   = (DIMW > CSR_DW) ? DIMW : CSR_DW;
   localparam int OFFW = DIMW + 19;

   function automatic logic in_store(input logic [OFFW-1:0] a);
      return 33'(a) < 33'(MAX_PIXELS);
   endfunction

   function automatic logic [DIMW-1:0] eff_dim(input logic [CSR_DW-1:0] raw);
      logic [CW-1:0] ext;
      ext = CW'(raw);
      if (ext < CW'(MIN_DIM)) return DIMW'(MIN_DIM);
      if (ext > CW'(MAX_DIM)) return DIMW'(MAX_DIM);
      return DIMW'(ext);
   endfunction

   // configuration
   logic [CSR_DW-1:0] width_ff, width_in, height_ff, height_in;
   logic [DIMW-1:0]   w_eff, h_eff;

   // captured request
   logic [1:0]  type_ff, type_in;
   logic [7:0]  cx_ff, cx_in, cy_ff, cy_in, rad_ff, rad_in;
   logic [15:0] val_ff, val_in;

   // clearing and frame state
   logic [AW-1:0]   clr_ff, clr_in;
   logic            sel_ff, sel_in;
   logic [PIXW-1:0] offset_ff, offset_in, count_ff, count_in, wh_ff, wh_in;
   logic [PIXW-1:0] idx_ff, idx_in;
   logic            done_ff, done_in;

   // drop walker
   logic [15:0]     r2_ff, r2_in, dy2_ff, dy2_in;
   logic [8:0]      sx_ff, sx_in, sy_ff, sy_in;
   logic [PIXW-1:0] base_ff, base_in;

   // render taps
   logic [TAP_W-1:0] rdk_ff, rdk_in, tapk_ff;
   logic             tapv_ff, tapin_ff;
   logic [15:0]      pn_ff [NUM_TAPS];
   logic [15:0]      cn_ff [NUM_TAPS];
   logic [15:0]      v1_ff, v1_in;
   logic signed [16:0]     xoff_ff, xoff_in, yoff_ff, yoff_in;
   logic signed [OFFW-1:0] prod_ff, prod_in, offs_ff, offs_in;
   logic             srcin_ff, srcin_in;
   logic [31:0]      pix_ff, pix_in;
   logic [15:0]      oidx_ff, oidx_in;
   logic [31:0]      opix_ff, opix_in;
   logic             odone_ff, odone_in;

   // memory ports
   logic            pa_we, pb_we, pl_re, src_we, src_re;
   logic [AW-1:0]   pl_waddr, pl_raddr, src_waddr, src_raddr;
   logic [15:0]     pl_wdata, pa_rdata, pb_rdata, prev_rdata, cur_rdata;
   logic [31:0]     src_rdata;

   // combinational helpers
   logic [CW-1:0]    x_hi, y_hi;
   logic [8:0]       y_end, x_last;
   logic signed [9:0]  dy, dx;
   logic signed [19:0] dy_sq, dx_sq;
   logic [16:0]      dsq_sum;
   logic             hit;
   logic [PIXW-1:0]  drop_addr, off_eff, tap_addr;
   logic [2*DIMW-1:0] cnt_full;
   logic [DIMW+CSR_DW-1:0] base_full;
   logic signed [17:0] ssum;
   logic signed [16:0] shalf, vdiff;
   logic signed [15:0] v1s, vnew;
   logic signed [OFFW-1:0] src_pick;

   assign w_eff = eff_dim(width_ff);
   assign h_eff = eff_dim(height_ff);

   assign x_hi   = CW'(cx_ff) + CW'(rad_ff);
   assign y_hi   = CW'(cy_ff) + CW'(rad_ff);
   assign y_end  = 9'(cy_ff) + 9'(rad_ff);
   assign x_last = 9'(cx_ff) + 9'(rad_ff) - 9'd1;
   assign dy     = $signed({1'b0, sy_ff}) - $signed({2'b00, cy_ff});
   assign dx     = $signed({1'b0, sx_ff}) - $signed({2'b00, cx_ff});
   assign dy_sq  = dy * dy;
   assign dx_sq  = dx * dx;
   assign dsq_sum = 17'(dx_sq[15:0]) + 17'(dy2_ff);
   assign hit    = (type_ff != REQ_DISC) || (dsq_sum < 17'(r2_ff));
   assign drop_addr = base_ff + PIXW'(sx_ff);

   assign cnt_full  = (2*DIMW)'(w_eff) * (2*DIMW)'(h_eff - DIMW'(2));
   assign base_full = (DIMW+CSR_DW)'(w_eff) * (DIMW+CSR_DW)'(sy_ff);
   assign off_eff   = (offset_ff >= count_ff) ? '0 : offset_ff;

   always_comb begin
      case (rdk_ff)
         TAP_WEST:  tap_addr = idx_ff - PIXW'(1);
         TAP_EAST:  tap_addr = idx_ff + PIXW'(1);
         TAP_NORTH: tap_addr = idx_ff - PIXW'(w_eff);
         TAP_SOUTH: tap_addr = idx_ff + PIXW'(w_eff);
         default:   tap_addr = idx_ff;
      endcase
   end

   assign ssum  = 18'($signed(pn_ff[TAP_WEST])) + 18'($signed(pn_ff[TAP_EAST]))
                + 18'($signed(pn_ff[TAP_NORTH])) + 18'($signed(pn_ff[TAP_SOUTH]));
   assign shalf = 17'(ssum >>> SPREAD_SHIFT);
   assign vdiff = shalf - 17'($signed(cn_ff[TAP_CENTRE]));
   assign v1s   = $signed(v1_ff);
   assign vnew  = v1s - (v1s >>> DAMP_SHIFT);

   // Displaced index falls back to the pixel itself outside the image.
   assign src_pick = (offs_ff < 0 || offs_ff >= $signed(OFFW'(wh_ff)))
                     ? $signed(OFFW'(idx_ff)) : offs_ff;

   assign prev_rdata = sel_ff ? pb_rdata : pa_rdata;
   assign cur_rdata  = sel_ff ? pa_rdata : pb_rdata;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      type_in   = type_ff;
      cx_in     = cx_ff;
      cy_in     = cy_ff;
      rad_in    = rad_ff;
      val_in    = val_ff;
      clr_in    = clr_ff;
      sel_in    = sel_ff;
      offset_in = offset_ff;
      count_in  = count_ff;
      wh_in     = wh_ff;
      idx_in    = idx_ff;
      done_in   = done_ff;
      r2_in     = r2_ff;
      dy2_in    = dy2_ff;
      sx_in     = sx_ff;
      sy_in     = sy_ff;
      base_in   = base_ff;
      rdk_in    = rdk_ff;
      v1_in     = v1_ff;
      xoff_in   = xoff_ff;
      yoff_in   = yoff_ff;
      prod_in   = prod_ff;
      offs_in   = offs_ff;
      srcin_in  = srcin_ff;
      pix_in    = pix_ff;
      oidx_in   = oidx_ff;
      opix_in   = opix_ff;
      odone_in  = odone_ff;

      pa_we     = 1'b0;
      pb_we     = 1'b0;
      pl_waddr  = clr_ff;
      pl_wdata  = '0;
      pl_re     = 1'b0;
      pl_raddr  = AW'(tap_addr);
      src_we    = 1'b0;
      src_waddr = AW'(load_index);
      src_re    = 1'b0;
      src_raddr = AW'(src_pick);

      if (csr_we) begin
         case (csr_index)
            CSR_FRAME_WIDTH:  width_in  = csr_wdata;
            CSR_FRAME_HEIGHT: height_in = csr_wdata;
            default: ;
         endcase
      end

      case (cmd.op)
         OP_CLEAR: begin
            pa_we  = 1'b1;
            pb_we  = 1'b1;
            clr_in = clr_ff + AW'(1);
         end
         OP_ACCEPT: begin
            type_in = req_type;
            cx_in   = center_x;
            cy_in   = center_y;
            rad_in  = radius;
            val_in  = 16'(-depth);
            src_we  = (req_type == REQ_LOAD) && (33'(load_index) < 33'(MAX_PIXELS));
         end
         OP_DCHK: begin
            r2_in = 16'(rad_ff) * 16'(rad_ff);
            sy_in = 9'(cy_ff) - 9'(rad_ff);
         end
         OP_DBASE: base_in = PIXW'(base_full);
         OP_DROW: begin
            dy2_in = dy_sq[15:0];
            sx_in  = 9'(cx_ff) - 9'(rad_ff);
         end
         OP_DCOL: begin
            pl_waddr = AW'(drop_addr);
            pl_wdata = val_ff;
            if (hit && in_store(OFFW'(drop_addr))) begin
               pa_we = !sel_ff;
               pb_we = sel_ff;
            end
            sx_in = sx_ff + 9'd1;
            if (sx_ff == x_last) begin
               sy_in   = sy_ff + 9'd1;
               base_in = base_ff + PIXW'(w_eff);
            end
         end
         OP_RSET: count_in = PIXW'(cnt_full);
         OP_RIDX: begin
            idx_in    = PIXW'(w_eff) + off_eff;
            done_in   = (off_eff == count_ff - PIXW'(1));
            offset_in = (off_eff == count_ff - PIXW'(1)) ? '0 : off_eff + PIXW'(1);
            wh_in     = count_ff + PIXW'(w_eff) + PIXW'(w_eff);
            rdk_in    = '0;
         end
         OP_RRD: begin
            pl_re  = 1'b1;
            rdk_in = rdk_ff + TAP_W'(1);
         end
         OP_RSUM: v1_in = 16'(vdiff);
         OP_RWR: begin
            pl_waddr = AW'(idx_ff);
            pl_wdata = vnew;
            if (in_store(OFFW'(idx_ff))) begin
               pa_we = sel_ff;
               pb_we = !sel_ff;
            end
            xoff_in = 17'($signed(cn_ff[TAP_WEST])) - 17'($signed(cn_ff[TAP_EAST]));
            yoff_in = 17'($signed(cn_ff[TAP_NORTH])) - 17'($signed(cn_ff[TAP_SOUTH]));
         end
         OP_RMUL: prod_in = OFFW'(yoff_ff) * $signed(OFFW'(w_eff));
         OP_ROFF: offs_in = $signed(OFFW'(idx_ff)) + prod_ff + OFFW'(xoff_ff);
         OP_RSRC: begin
            src_re   = 1'b1;
            srcin_in = in_store(OFFW'(src_pick));
         end
         OP_RSWT: pix_in = srcin_ff ? src_rdata : '0;
         OP_ROUT: begin
            oidx_in  = 16'(idx_ff);
            opix_in  = pix_ff;
            odone_in = done_ff;
            if (done_ff) sel_in = !sel_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_RESET;
         height_ff <= DIM_RESET;
         clr_ff    <= '0;
         sel_ff    <= 1'b0;
         offset_ff <= '0;
         rdk_ff    <= '0;
         tapv_ff   <= 1'b0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         clr_ff    <= clr_in;
         sel_ff    <= sel_in;
         offset_ff <= offset_in;
         rdk_ff    <= rdk_in;
         tapv_ff   <= pl_re;
      end
   end

   always_ff @(posedge clock) begin
      type_ff  <= type_in;
      cx_ff    <= cx_in;
      cy_ff    <= cy_in;
      rad_ff   <= rad_in;
      val_ff   <= val_in;
      count_ff <= count_in;
      wh_ff    <= wh_in;
      idx_ff   <= idx_in;
      done_ff  <= done_in;
      r2_ff    <= r2_in;
      dy2_ff   <= dy2_in;
      sx_ff    <= sx_in;
      sy_ff    <= sy_in;
      base_ff  <= base_in;
      v1_ff    <= v1_in;
      xoff_ff  <= xoff_in;
      yoff_ff  <= yoff_in;
      prod_ff  <= prod_in;
      offs_ff  <= offs_in;
      srcin_ff <= srcin_in;
      pix_ff   <= pix_in;
      oidx_ff  <= oidx_in;
      opix_ff  <= opix_in;
      odone_ff <= odone_in;
      tapk_ff  <= rdk_ff;
      tapin_ff <= in_store(OFFW'(tap_addr));
      // Read data returns in the cycle after its address; entries beyond storage read as zero.
      if (tapv_ff) begin
         pn_ff[tapk_ff] <= tapin_ff ? prev_rdata : '0;
         cn_ff[tapk_ff] <= tapin_ff ? cur_rdata : '0;
      end
   end

   wrr_ram #(.WIDTH(16), .DEPTH(MAX_PIXELS)) u_plane_a (
      .clock   (clock),
      .wr_en   (pa_we),
      .wr_addr (pl_waddr),
      .wr_data (pl_wdata),
      .rd_en   (pl_re),
      .rd_addr (pl_raddr),
      .rd_data (pa_rdata)
   );

   wrr_ram #(.WIDTH(16), .DEPTH(MAX_PIXELS)) u_plane_b (
      .clock   (clock),
      .wr_en   (pb_we),
      .wr_addr (pl_waddr),
      .wr_data (pl_wdata),
      .rd_en   (pl_re),
      .rd_addr (pl_raddr),
      .rd_data (pb_rdata)
   );

   wrr_ram #(.WIDTH(32), .DEPTH(MAX_PIXELS)) u_source (
      .clock   (clock),
      .wr_en   (src_we),
      .wr_addr (src_waddr),
      .wr_data (pixel_data),
      .rd_en   (src_re),
      .rd_addr (src_raddr),
      .rd_data (src_rdata)
   );

   assign status.clear_last = (clr_ff == AW'(MAX_PIXELS - 1));
   assign status.drop_ok    = (x_hi <= CW'(w_eff)) && (y_hi <= CW'(h_eff))
                            && (cx_ff >= rad_ff) && (cy_ff >= rad_ff);
   assign status.row_end    = (sy_ff == y_end);
   assign status.col_last   = (sx_ff == x_last);
   assign status.rd_last    = (rdk_ff == TAP_CENTRE);

   assign out_index  = oidx_ff;
   assign out_pixel  = opix_ff;
   assign frame_done = odone_ff;

endmodule

// ===== rtl/water_ripple_renderer.sv =====
// Ripple renderer with refraction over a loaded source image.
// Request channel (req_if): req_type selects a load of one source pixel, a disc
// drop, a square drop or the rendering of the next pixel outside the first and
// last rows. Loads and drops produce nothing; a drop writes the negated depth
// into the wave plane at each pixel that its shape covers.
// A render transaction produces one result on rsp_if, and the next request is
// accepted only once that result has entered the output register. The cost is
// set by the single read port of each wave plane, which serves the five tap
// reads (four neighbours and the pixel itself) one per cycle, followed by the
// gradient multiply and the source image read.
// One transaction is in work at a time; a finished result waits in the output
// register while the next request is accepted, and a stalled receiver holds
// back only the next render result, which waits at its end until the output
// register frees.
// After reset both wave planes are cleared, one entry per cycle, and no request
// is accepted meanwhile. The csr port writes frame_width (index 0) and
// frame_height (index 1); the user must make these writes only while no
// transaction is in work, and the block itself does not enforce this.
module water_ripple_renderer
   import wrr_pkg::*;
#(
   parameter int MAX_DIM    = 256,
   parameter int MAX_PIXELS = 65536
) (
   input  logic              clock,
   input  logic              reset,
   wrr_req_if.sink           req_if,
   wrr_rsp_if.source         rsp_if,
   input  logic              csr_we,
   input  logic [CSR_IW-1:0] csr_index,
   input  logic [CSR_DW-1:0] csr_wdata
);

   dp_cmd_type    cmd;
   dp_status_type status;

   wrr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_type  (req_if.req_type),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   wrr_dp #(.MAX_DIM(MAX_DIM), .MAX_PIXELS(MAX_PIXELS)) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_type   (req_if.req_type),
      .load_index (req_if.load_index),
      .pixel_data (req_if.pixel_data),
      .center_x   (req_if.center_x),
      .center_y   (req_if.center_y),
      .radius     (req_if.radius),
      .depth      (req_if.depth),
      .out_index  (rsp_if.out_index),
      .out_pixel  (rsp_if.out_pixel),
      .frame_done (rsp_if.frame_done)
   );

endmodule
